[rtl/assert_macros.svh]
// Assertion helpers used by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define TTPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define TTPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/ttpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ttpq_pkg;

  // Field widths fixed by the interface
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned SESS_W    = 64;
  localparam int unsigned STEP_W    = 3;

  // Event codes
  localparam logic [FUNC_W-1:0] FUNC_CLAIM   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_AUDIO   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DONE    = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

  // Status codes
  localparam logic ST_ACTED   = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 4'd1;
  localparam logic [CFG_W-1:0]     STARTUP_RST  = 5'd3;
  localparam logic [CFG_W-1:0]     CAPACITY_RST = 5'd10;

  // Compare steps of the shared unit: four session words, then the sequence
  localparam logic [STEP_W-1:0] CMP_HI_UP = 3'd0;
  localparam logic [STEP_W-1:0] CMP_HI_LO = 3'd1;
  localparam logic [STEP_W-1:0] CMP_LO_UP = 3'd2;
  localparam logic [STEP_W-1:0] CMP_LO_LO = 3'd3;
  localparam logic [STEP_W-1:0] CMP_SEQ   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_DECIDE,
    S_WALK,
    S_EMIT,
    S_SINGLE,
    S_STAT
  } state_e;

  typedef struct packed {
    logic have_claim;
    logic have_audio;
    logic have_sess;
    logic released;
    logic playing;
  } flags_t;

  typedef struct packed {
    logic en;
    logic first;
    logic seq;
  } cmp_op_t;

  typedef struct packed {
    logic eq;
    logic le;
  } cmp_res_t;

endpackage

`default_nettype wire

[rtl/talk_turn_playout_queue.sv]
// Sequence: accept, the compare steps, a decide state, then a ring read and an
//   emit per handle read from the ring (a flush walks every queued entry), the
//   handle of a duplicate audio beat, then the status beat.
// A new event is accepted only in idle, once the status beat is sent; output
//   stalls hold the emit states. The shared comparator and the single ring
//   read port serialize the work. Reset: async, active low.
`timescale 1ns / 1ps
`default_nettype none

module talk_turn_playout_queue
  import ttpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned REF_BITS    = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // event input
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [FUNC_W-1:0]    func_i,
  input  wire logic [SESS_W-1:0]    session_high_i,
  input  wire logic [SESS_W-1:0]    session_low_i,
  input  wire logic [SEQ_W-1:0]     sequence_req_i,
  input  wire logic [REF_BITS-1:0]  batch_ref_i,
  // result output
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [KIND_W-1:0]    result_kind_o,
  output logic      [REF_BITS-1:0]  out_ref_o,
  output logic                      status_o,
  output logic      [OCC_W-1:0]     occupancy_o,
  output logic                      is_playing_o,
  output logic                      is_released_o,
  output logic                      last_o
);

  `include "assert_macros.svh"

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned SUM_W = IDX_W + 1;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q;

  logic [CFG_W-1:0] thr_cfg_q, cap_cfg_q;

  logic [FUNC_W-1:0]   func_q;
  logic [SESS_W-1:0]   hi_q, lo_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [REF_BITS-1:0] ref_q;

  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SESS_W-1:0] cur_hi_q, cur_hi_d, cur_lo_q, cur_lo_d;
  logic [SEQ_W-1:0]  last_audio_q, last_audio_d, last_claim_q, last_claim_d;
  flags_t            flags_q, flags_d;

  logic [IDX_W-1:0] walk_ptr_q;
  logic [CNT_W-1:0] walk_left_q, walk_n;
  logic [KIND_W-1:0] walk_kind_q, walk_kind_d;
  logic             single_q, single_d;
  logic             st_q, st_d;
  logic             wr_pend_q, wr_pend_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;

  logic                out_valid_q;
  logic [KIND_W-1:0]   out_kind_q;
  logic [REF_BITS-1:0] out_ref_q;
  logic                out_st_q, out_play_q, out_rel_q, out_last_q;
  logic [OCC_W-1:0]    out_occ_q;

  // control from the output block
  logic    in_acc, out_free, out_load;
  logic    rd_en, wr_en;
  cmp_op_t cmp_op;
  cmp_res_t cmp_res;
  logic [SEQ_W-1:0] opa, opb;
  logic [REF_BITS-1:0] rd_data;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_cfg_q <= STARTUP_RST;
      cap_cfg_q <= CAPACITY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_STARTUP) begin
        thr_cfg_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_CAPACITY) begin
        cap_cfg_q <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Capture the event
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      hi_q   <= session_high_i;
      lo_q   <= session_low_i;
      seq_q  <= sequence_req_i;
      ref_q  <= batch_ref_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared comparator: session words, then the sequence number
  // ---------------------------------------------------------------------------
  always_comb begin
    case (step_q)
      CMP_HI_UP: begin
        opa = hi_q[SESS_W-1:SEQ_W];
        opb = cur_hi_q[SESS_W-1:SEQ_W];
      end
      CMP_HI_LO: begin
        opa = hi_q[SEQ_W-1:0];
        opb = cur_hi_q[SEQ_W-1:0];
      end
      CMP_LO_UP: begin
        opa = lo_q[SESS_W-1:SEQ_W];
        opb = cur_lo_q[SESS_W-1:SEQ_W];
      end
      CMP_LO_LO: begin
        opa = lo_q[SEQ_W-1:0];
        opb = cur_lo_q[SEQ_W-1:0];
      end
      default: begin
        opa = seq_q;
        opb = (func_q == FUNC_CLAIM) ? last_claim_q : last_audio_q;
      end
    endcase
  end

  ttpq_cmp_unit u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (cmp_op),
    .opa_i  (opa),
    .opb_i  (opb),
    .res_o  (cmp_res)
  );

  // ---------------------------------------------------------------------------
  // Decide: final state and the list of beats to send
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [CMP_W-1:0] cap_c, thr_c, depth_c;
    logic [SUM_W-1:0] sum;
    logic             sess_change;
    flags_t           f;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] hd;

    depth_c = CMP_W'(QUEUE_DEPTH);
    cap_c   = CMP_W'(cap_cfg_q);
    if (cap_c == '0) begin
      cap_c = CMP_W'(1);
    end else if (cap_c > depth_c) begin
      cap_c = depth_c;
    end
    thr_c = CMP_W'(thr_cfg_q);
    if (thr_c == '0) begin
      thr_c = CMP_W'(1);
    end

    sess_change  = flags_q.have_sess && !cmp_res.eq;
    f            = flags_q;
    cnt          = count_q;
    hd           = head_q;
    cur_hi_d     = cur_hi_q;
    cur_lo_d     = cur_lo_q;
    last_audio_d = last_audio_q;
    last_claim_d = last_claim_q;
    walk_n       = '0;
    walk_kind_d  = KIND_FREE;
    single_d     = 1'b0;
    st_d         = ST_ACTED;
    wr_pend_d    = 1'b0;
    wr_idx_d     = '0;
    sum          = '0;

    case (func_q)
      FUNC_CLAIM: begin
        if (sess_change) begin
          walk_n = count_q;
          cnt    = '0;
          hd     = '0;
          f      = '0;
        end
        if (!f.have_sess) begin
          cur_hi_d    = hi_q;
          cur_lo_d    = lo_q;
          f.have_sess = 1'b1;
        end
        if (f.have_claim && cmp_res.le) begin
          st_d = ST_IGNORED;
        end else begin
          if (f.have_claim) begin
            walk_n       = count_q;
            cnt          = '0;
            hd           = '0;
            f.playing    = 1'b0;
            f.have_audio = 1'b0;
          end
          last_claim_d = seq_q;
          f.have_claim = 1'b1;
          f.released   = 1'b0;
        end
      end
      FUNC_RELEASE: begin
        if (flags_q.have_sess && cmp_res.eq) begin
          f.released = 1'b1;
          if (count_q != '0) begin
            f.playing = 1'b1;
          end else begin
            f = '0;
          end
        end else begin
          st_d = ST_IGNORED;
        end
      end
      FUNC_AUDIO: begin
        if (sess_change) begin
          walk_n = count_q;
          cnt    = '0;
          hd     = '0;
          f      = '0;
        end
        if (!f.have_sess) begin
          cur_hi_d     = hi_q;
          cur_lo_d     = lo_q;
          f.have_sess  = 1'b1;
          f.have_audio = 1'b0;
        end
        if (f.have_audio && cmp_res.le) begin
          single_d = 1'b1;
          st_d     = ST_IGNORED;
        end else begin
          last_audio_d = seq_q;
          f.have_audio = 1'b1;
          // tail slot, wrapped once
          sum = SUM_W'(hd) + SUM_W'(cnt);
          if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
          end
          wr_pend_d = 1'b1;
          wr_idx_d  = IDX_W'(sum);
          // drop the oldest when full
          if (CMP_W'(cnt) >= cap_c) begin
            walk_n = CNT_W'(1);
            hd     = (hd == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : hd + IDX_W'(1);
            cnt    = cnt - CNT_W'(1);
          end
          cnt = cnt + CNT_W'(1);
          if (CMP_W'(cnt) >= thr_c) begin
            f.playing = 1'b1;
          end
        end
      end
      FUNC_POP: begin
        if (flags_q.playing && count_q != '0) begin
          walk_n      = CNT_W'(1);
          walk_kind_d = KIND_POP;
          hd          = (hd == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : hd + IDX_W'(1);
          cnt         = cnt - CNT_W'(1);
        end else begin
          st_d = ST_IGNORED;
        end
      end
      FUNC_DONE: begin
        if (count_q == '0) begin
          f.playing = 1'b0;
          if (flags_q.released) begin
            f = '0;
          end
        end
      end
      default: begin
        st_d = ST_IGNORED;
      end
    endcase

    flags_d = f;
    count_d = cnt;
    head_d  = hd;
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (step_q == CMP_SEQ) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (walk_n != '0) begin
          state_d = S_WALK;
        end else if (single_d) begin
          state_d = S_SINGLE;
        end else begin
          state_d = S_STAT;
        end
      end
      S_WALK: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (walk_left_q != CNT_W'(1)) begin
            state_d = S_WALK;
          end else if (single_q) begin
            state_d = S_SINGLE;
          end else begin
            state_d = S_STAT;
          end
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          state_d = S_STAT;
        end
      end
      S_STAT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall_o   = 1'b1;
    out_load     = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    cmp_op.en    = 1'b0;
    cmp_op.first = 1'b0;
    cmp_op.seq   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
      end
      S_CMP: begin
        cmp_op.en    = 1'b1;
        cmp_op.first = (step_q == CMP_HI_UP);
        cmp_op.seq   = (step_q == CMP_SEQ);
      end
      S_WALK: begin
        rd_en = 1'b1;
      end
      S_EMIT, S_SINGLE: begin
        out_load = out_free;
      end
      S_STAT: begin
        out_load = out_free;
        wr_en    = out_free && wr_pend_q;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= CMP_HI_UP;
      head_q       <= '0;
      count_q      <= '0;
      cur_hi_q     <= '0;
      cur_lo_q     <= '0;
      last_audio_q <= '0;
      last_claim_q <= '0;
      flags_q      <= '0;
      walk_left_q  <= '0;
      single_q     <= 1'b0;
      wr_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // advance the compare step
      if (in_acc) begin
        step_q <= CMP_HI_UP;
      end else if (state_q == S_CMP) begin
        step_q <= step_q + STEP_W'(1);
      end
      // commit the event
      if (state_q == S_DECIDE) begin
        head_q       <= head_d;
        count_q      <= count_d;
        cur_hi_q     <= cur_hi_d;
        cur_lo_q     <= cur_lo_d;
        last_audio_q <= last_audio_d;
        last_claim_q <= last_claim_d;
        flags_q      <= flags_d;
        walk_left_q  <= walk_n;
        single_q     <= single_d;
        wr_pend_q    <= wr_pend_d;
      end else if (state_q == S_EMIT && out_free) begin
        walk_left_q <= walk_left_q - CNT_W'(1);
      end
      // hold the beat until taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk pointer and per-event plan
  always_ff @(posedge clk_i) begin
    if (state_q == S_DECIDE) begin
      walk_ptr_q  <= head_q;
      walk_kind_q <= walk_kind_d;
      st_q        <= st_d;
      wr_idx_q    <= wr_idx_d;
    end else if (state_q == S_EMIT && out_free) begin
      walk_ptr_q <= (walk_ptr_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : walk_ptr_q + IDX_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Handle ring
  // ---------------------------------------------------------------------------
  ttpq_ring #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (REF_BITS)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx_q),
    .wr_data_i (ref_q),
    .rd_en_i   (rd_en),
    .rd_idx_i  (walk_ptr_q),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Output beat register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_occ_q  <= OCC_W'(count_q);
      out_play_q <= flags_q.playing;
      out_rel_q  <= flags_q.released;
      case (state_q)
        S_EMIT: begin
          out_kind_q <= walk_kind_q;
          out_ref_q  <= rd_data;
          out_st_q   <= ST_ACTED;
          out_last_q <= 1'b0;
        end
        S_SINGLE: begin
          out_kind_q <= KIND_FREE;
          out_ref_q  <= ref_q;
          out_st_q   <= ST_ACTED;
          out_last_q <= 1'b0;
        end
        default: begin
          out_kind_q <= KIND_STATUS;
          out_ref_q  <= '0;
          out_st_q   <= st_q;
          out_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign out_ref_o     = out_ref_q;
  assign status_o      = out_st_q;
  assign occupancy_o   = out_occ_q;
  assign is_playing_o  = out_play_q;
  assign is_released_o = out_rel_q;
  assign last_o        = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TTPQ_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `TTPQ_ASSERT(a_walk_nonzero, (state_q == S_WALK) |-> (walk_left_q != '0), "walk with no handles")
  `TTPQ_ASSERT(a_pop_playing, (out_valid_o && result_kind_o == KIND_POP) |-> is_playing_o,
               "pop beat while not playing")
  `TTPQ_ASSERT(a_rel_session, flags_q.released |-> flags_q.have_sess, "released flag without a session")

endmodule

`default_nettype wire

[rtl/ttpq_cmp_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shared 32-bit comparator: folds word equality over a chain of steps,
// or captures an unsigned less-or-equal result.
module ttpq_cmp_unit
  import ttpq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmp_op_t          op_i,
  input  wire logic [SEQ_W-1:0] opa_i,
  input  wire logic [SEQ_W-1:0] opb_i,
  output cmp_res_t              res_o
);

  logic eq_q, eq_d;
  logic le_q, le_d;

  // Fold or capture the current step
  always_comb begin
    eq_d = eq_q;
    le_d = le_q;
    if (op_i.en) begin
      if (op_i.seq) begin
        le_d = (opa_i <= opb_i);
      end else begin
        eq_d = (op_i.first ? 1'b1 : eq_q) & (opa_i == opb_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_q <= 1'b0;
      le_q <= 1'b0;
    end else begin
      eq_q <= eq_d;
      le_q <= le_d;
    end
  end

  assign res_o.eq = eq_q;
  assign res_o.le = le_q;

endmodule

`default_nettype wire

[rtl/ttpq_ring.sv]
`timescale 1ns / 1ps
`default_nettype none

// Handle ring: one write port, one registered read port.
module ttpq_ring #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_idx_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_idx_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write the new handle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_idx_i];
    end
  end

endmodule

`default_nettype wire
